// ===== sv/piezo_trigger_to_midi_notes_macros.svh =====
// -----------------------------------------------------------------------------
// Piezo trigger to MIDI notes - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// -----------------------------------------------------------------------------
`ifndef PIEZO_TRIGGER_TO_MIDI_NOTES_MACROS_SVH
`define PIEZO_TRIGGER_TO_MIDI_NOTES_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define PTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptm assertion failed");
// Next-cycle implication, disabled while reset is held.
`define PTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptm assertion failed");
`else
`define PTM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/ptm_pkg.sv =====
// -----------------------------------------------------------------------------
// Piezo trigger to MIDI notes - package
// Field types, register indexes and MIDI codes.
// -----------------------------------------------------------------------------
package ptm_pkg;

    typedef logic [1:0]  t_pad;
    typedef logic [9:0]  t_sample;
    typedef logic [31:0] t_time;
    typedef logic [3:0]  t_code;
    typedef logic [7:0]  t_status;
    typedef logic [6:0]  t_note;
    typedef logic [6:0]  t_velocity;
    typedef logic [3:0]  t_channel;
    typedef logic [15:0] t_hold;
    typedef logic [2:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    // register map
    localparam t_cfg_idx CFG_THRESHOLD = 3'd0;
    localparam t_cfg_idx CFG_CHANNEL   = 3'd1;
    localparam t_cfg_idx CFG_HOLD      = 3'd2;
    localparam t_cfg_idx CFG_NOTE_PAD0 = 3'd3;
    localparam t_cfg_idx CFG_NOTE_PAD1 = 3'd4;
    localparam t_cfg_idx CFG_NOTE_PAD2 = 3'd5;
    localparam t_cfg_idx CFG_NOTE_PAD3 = 3'd6;

    localparam int NOTE_REGS = 4;

    // USB MIDI code index and status
    localparam t_code   CODE_NOTE_ON    = 4'h9;
    localparam t_code   CODE_NOTE_OFF   = 4'h8;
    localparam t_status STATUS_NOTE_ON  = 8'h90;
    localparam t_status STATUS_NOTE_OFF = 8'h80;

    // reset values
    localparam t_sample THRESHOLD_RST = 10'd100;
    localparam t_hold   HOLD_RST      = 16'd80;
    localparam t_note   NOTE0_RST     = 7'd48;
    localparam t_note   NOTE1_RST     = 7'd50;
    localparam t_note   NOTE2_RST     = 7'd52;
    localparam t_note   NOTE3_RST     = 7'd55;

    // velocity scaling: sample * 127 / 1023
    localparam int VEL_SCALE   = 127;
    localparam int ADC_FULL    = 1023;

endpackage

// ===== sv/ptm_ifs.sv =====
// -----------------------------------------------------------------------------
// Piezo trigger to MIDI notes - channel interfaces
// Sample input, MIDI event output and register write channels.
// -----------------------------------------------------------------------------
interface ptm_in_if import ptm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_pad    pad;
    t_sample sample;
    t_time   time_ms;

    modport source (output valid, output pad, output sample, output time_ms, input ready);
    modport sink   (input valid, input pad, input sample, input time_ms, output ready);
endinterface

interface ptm_out_if import ptm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_code     code_index;
    t_status   status;
    t_note     note;
    t_velocity velocity;
    t_pad      source_pad;

    modport source (output valid, output code_index, output status, output note,
                    output velocity, output source_pad, input ready);
    modport sink   (input valid, input code_index, input status, input note,
                    input velocity, input source_pad, output ready);
endinterface

interface ptm_cfg_if import ptm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/piezo_trigger_to_midi_notes.sv =====
// -----------------------------------------------------------------------------
// Piezo trigger to MIDI notes
// Turns pad samples into MIDI note-on / note-off events.
// -----------------------------------------------------------------------------
// Takes one sample per clock: each sample (pad, 10-bit reading, millisecond
// timestamp) lands in an input register, where a single pass of logic checks
// it against that pad's state and loads at most one event into the output
// register once that register is free; the sustained rate is one sample per
// cycle for as long as the event sink keeps up. An idle pad
// whose sample is strictly above the threshold gives a note-on (code 9,
// status 0x90|channel) with velocity floor(sample*127/1023), at least 1, and
// starts timing; an active pad gives a note-off (code 8, status 0x80|channel,
// velocity 0) on the first sample whose wrapped timestamp distance from the
// onset reaches hold_ms (0 acts as 1). Other samples, and samples for a pad
// index at or above NUM_PADS, produce nothing. Register writes are always
// accepted and must only be issued while no sample or event is in flight.
// -----------------------------------------------------------------------------
`include "piezo_trigger_to_midi_notes_macros.svh"

module piezo_trigger_to_midi_notes
    import ptm_pkg::*;
#(
    parameter int NUM_PADS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptm_in_if.sink       i_in,
    ptm_out_if.source    o_out,
    ptm_cfg_if.sink      i_cfg
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_sample  r_threshold;
    t_channel r_channel;
    t_hold    r_hold;
    t_note    r_note [NOTE_REGS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_channel   <= '0;
            r_hold      <= HOLD_RST;
            r_note[0]   <= NOTE0_RST;
            r_note[1]   <= NOTE1_RST;
            r_note[2]   <= NOTE2_RST;
            r_note[3]   <= NOTE3_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_THRESHOLD: r_threshold <= i_cfg.data[9:0];
                CFG_CHANNEL:   r_channel   <= i_cfg.data[3:0];
                CFG_HOLD:      r_hold      <= i_cfg.data;
                CFG_NOTE_PAD0: r_note[0]   <= i_cfg.data[6:0];
                CFG_NOTE_PAD1: r_note[1]   <= i_cfg.data[6:0];
                CFG_NOTE_PAD2: r_note[2]   <= i_cfg.data[6:0];
                CFG_NOTE_PAD3: r_note[3]   <= i_cfg.data[6:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic    r_s1_valid;
    t_pad    r_s1_pad;
    t_sample r_s1_sample;
    t_time   r_s1_time;

    logic    r_out_valid;
    logic    w_out_free;   // output register can take a new event
    logic    w_hit;        // sample in input register makes an event
    logic    w_s1_go;      // sample leaves the input register

    assign w_out_free = !r_out_valid || o_out.ready;
    // a sample that makes no event can retire even while the output stalls
    assign w_s1_go    = r_s1_valid && (w_out_free || !w_hit);
    assign i_in.ready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_pad    <= i_in.pad;
            r_s1_sample <= i_in.sample;
            r_s1_time   <= i_in.time_ms;
        end
    end

    // ---------------------------------------------------------------
    // Per-pad state
    // ---------------------------------------------------------------
    logic [NUM_PADS-1:0] r_active;
    t_time               r_onset [NUM_PADS];   // valid only while pad active

    // ---------------------------------------------------------------
    // Decision logic
    // ---------------------------------------------------------------
    logic      w_pad_ok;
    logic      w_act;
    t_time     w_onset;
    t_time     w_diff;
    t_hold     w_hold_eff;
    logic      w_on;
    logic      w_off;
    logic [16:0] w_prod;      // sample * 127, at most 129921
    logic [6:0]  w_q0;        // prod >> 10
    logic [10:0] w_rem;       // prod - q0*1023, below 2*1023
    t_velocity w_quot;
    t_velocity w_vel;
    t_note     w_note;

    always_comb begin
        w_pad_ok = (32'(r_s1_pad) < NUM_PADS);
        w_act    = 1'b0;
        w_onset  = '0;
        for (int i = 0; i < NUM_PADS; i++) begin
            if (32'(r_s1_pad) == i) begin
                w_act   = r_active[i];
                w_onset = r_onset[i];
            end
        end
    end

    assign w_diff     = r_s1_time - w_onset;
    assign w_hold_eff = (r_hold == '0) ? 16'd1 : r_hold;
    assign w_off      = w_act && (w_diff >= {16'd0, w_hold_eff});
    assign w_on       = !w_act && (r_s1_sample > r_threshold);
    assign w_hit      = w_pad_ok && (w_on || w_off);

    // divide by 1023: x/1024 underestimates by at most one
    assign w_prod = {r_s1_sample, 7'd0} - {7'd0, r_s1_sample};
    assign w_q0   = w_prod[16:10];
    assign w_rem  = {1'b0, w_prod[9:0]} + {4'd0, w_q0};
    assign w_quot = (w_rem >= 11'(ADC_FULL)) ? (w_q0 + 7'd1) : w_q0;
    assign w_vel  = (w_quot == '0) ? 7'd1 : w_quot;

    always_comb begin
        case (r_s1_pad)
            2'd0:    w_note = r_note[0];
            2'd1:    w_note = r_note[1];
            2'd2:    w_note = r_note[2];
            default: w_note = r_note[3];
        endcase
    end

    // state update happens as the sample retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (w_s1_go && w_pad_ok) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                if (32'(r_s1_pad) == i) begin
                    if (w_on) begin
                        r_active[i] <= 1'b1;
                    end else if (w_off) begin
                        r_active[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_pad_ok && w_on) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                if (32'(r_s1_pad) == i) begin
                    r_onset[i] <= r_s1_time;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    t_code     r_out_code;
    t_status   r_out_status;
    t_note     r_out_note;
    t_velocity r_out_vel;
    t_pad      r_out_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid && w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid && w_hit) begin
            r_out_code   <= w_on ? CODE_NOTE_ON : CODE_NOTE_OFF;
            r_out_status <= (w_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'd0, r_channel};
            r_out_note   <= w_note;
            r_out_vel    <= w_on ? w_vel : 7'd0;
            r_out_pad    <= r_s1_pad;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_index = r_out_code;
    assign o_out.status     = r_out_status;
    assign o_out.note       = r_out_note;
    assign o_out.velocity   = r_out_vel;
    assign o_out.source_pad = r_out_pad;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // note-on carries a nonzero velocity, note-off carries zero
    `PTM_ASSERT_NOW(a_vel_matches_code, i_clk, i_rst_n, r_out_valid, ((r_out_code == CODE_NOTE_ON) == (r_out_vel != 7'd0)))
    // a retired note-on raises exactly one more active pad
    `PTM_ASSERT_NEXT(a_on_sets_active, i_clk, i_rst_n, w_s1_go && w_hit && w_on, ($countones(r_active) == $past($countones(r_active)) + 1))
    // a retired note-off drops exactly one active pad
    `PTM_ASSERT_NEXT(a_off_clears_active, i_clk, i_rst_n, w_s1_go && w_hit && w_off, ($countones(r_active) + 1 == $past($countones(r_active))))

endmodule

// ===== dv/piezo_trigger_to_midi_notes_checker.sv =====
// ----------------------------------------------------------------------------
// Piezo trigger to MIDI notes - scoreboard
// Watches the sample, event and register channels, keeps its own copy of
// the pad state and settings, and checks each MIDI event against it.
// ----------------------------------------------------------------------------
module piezo_trigger_to_midi_notes_checker
    import ptm_pkg::*;
#(
    parameter int NUM_PADS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ptm_in_if    i_in,
    ptm_out_if   i_ev,
    ptm_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_code     code;
        t_status   status;
        t_note     note;
        t_velocity velocity;
        t_pad      pad;
    } t_midi_event;

    // shadow settings
    t_sample  thr_r;
    t_channel chan_r;
    t_hold    hold_r;
    t_note    note_r[NOTE_REGS];

    // shadow pad state
    logic     pad_on[NUM_PADS];
    t_time    onset_r[NUM_PADS];

    t_midi_event events_due[$];
    int          mismatch_cnt = 0;
    int          pending_cnt = 0;

    assign o_errors  = mismatch_cnt;
    assign o_pending = pending_cnt;

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("MIDI event %s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Event caused by one sample, if any; updates the pad state.
    function automatic bit next_midi_event(input t_pad p, input t_sample s, input t_time t,
                                           output t_midi_event ev);
        int unsigned span;
        int unsigned vel;
        t_time       elapsed;

        ev = '{default: '0};
        if (int'(p) >= NUM_PADS)
            return 1'b0;
        span = (hold_r == '0) ? 1 : int'(hold_r);
        ev.note = note_r[int'(p) % NOTE_REGS];
        ev.pad  = p;

        if (!pad_on[p]) begin
            if (s <= thr_r)
                return 1'b0;
            vel = (int'(s) * VEL_SCALE) / ADC_FULL;
            if (vel < 1)
                vel = 1;
            pad_on[p]   = 1'b1;
            onset_r[p]  = t;
            ev.code     = CODE_NOTE_ON;
            ev.status   = STATUS_NOTE_ON | t_status'(chan_r);
            ev.velocity = t_velocity'(vel);
            return 1'b1;
        end

        elapsed = t - onset_r[p];
        if (elapsed >= span) begin
            pad_on[p]   = 1'b0;
            ev.code     = CODE_NOTE_OFF;
            ev.status   = STATUS_NOTE_OFF | t_status'(chan_r);
            ev.velocity = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_midi_event want;
        t_midi_event made;

        if (!i_rst_n) begin
            thr_r     = THRESHOLD_RST;
            chan_r    = '0;
            hold_r    = HOLD_RST;
            note_r[0] = NOTE0_RST;
            note_r[1] = NOTE1_RST;
            note_r[2] = NOTE2_RST;
            note_r[3] = NOTE3_RST;
            for (int i = 0; i < NUM_PADS; i++) begin
                pad_on[i]  = 1'b0;
                onset_r[i] = '0;
            end
            events_due.delete();
        end else begin
            // older events leave before a new sample's event is queued
            if (i_ev.valid && i_ev.ready) begin
                if (events_due.size() == 0) begin
                    $error("unexpected MIDI event: code %0d status %0d note %0d pad %0d",
                           i_ev.code_index, i_ev.status, i_ev.note, i_ev.source_pad);
                    mismatch_cnt++;
                end else begin
                    want = events_due.pop_front();
                    check_field("code_index", want.code, i_ev.code_index);
                    check_field("status", want.status, i_ev.status);
                    check_field("note", want.note, i_ev.note);
                    check_field("velocity", want.velocity, i_ev.velocity);
                    check_field("source_pad", want.pad, i_ev.source_pad);
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_THRESHOLD: thr_r     = i_cfg.data[9:0];
                    CFG_CHANNEL:   chan_r    = i_cfg.data[3:0];
                    CFG_HOLD:      hold_r    = i_cfg.data;
                    CFG_NOTE_PAD0: note_r[0] = i_cfg.data[6:0];
                    CFG_NOTE_PAD1: note_r[1] = i_cfg.data[6:0];
                    CFG_NOTE_PAD2: note_r[2] = i_cfg.data[6:0];
                    CFG_NOTE_PAD3: note_r[3] = i_cfg.data[6:0];
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                if (next_midi_event(i_in.pad, i_in.sample, i_in.time_ms, made))
                    events_due.push_back(made);
            end
        end
        pending_cnt = events_due.size();
    end

endmodule

// ===== dv/piezo_trigger_to_midi_notes_test.sv =====
// ----------------------------------------------------------------------------
// Piezo trigger to MIDI notes - regression top
// Drives pad samples and register writes into the block under random flow
// control; the scoreboard beside it predicts and checks every MIDI event.
// ----------------------------------------------------------------------------
module piezo_trigger_to_midi_notes_test;
    import ptm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       PADS       = 4;
    localparam int       CYCLE_CAP  = 400000;  // far above the slowest legal run
    localparam int       DRAIN_WAIT = 4;       // two-stage pipe plus margin
    localparam t_cfg_idx CFG_UNUSED = 3'd7;    // unmapped index, must be ignored

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptm_in_if  sample_ch ();
    ptm_out_if event_ch ();
    ptm_cfg_if reg_ch ();

    int errors;
    int pending;
    int cycle_cnt = 0;

    // flow-control knobs, percent of cycles spent idle
    int send_idle_pct = 19;
    int recv_idle_pct = 69;

    // current register settings, used only to shape the stimulus
    t_sample cur_thr  = THRESHOLD_RST;
    t_hold   cur_hold = HOLD_RST;

    // stimulus bookkeeping: running clock and per-pad strike tracking, so that
    // timestamps can be aimed right at the end of the hold window
    t_time clock_ms;
    t_time strike_ms[PADS];
    logic  armed[PADS];
    int    rand_cnt = 0;

    piezo_trigger_to_midi_notes #(
        .NUM_PADS (PADS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (event_ch),
        .i_cfg   (reg_ch)
    );

    piezo_trigger_to_midi_notes_checker #(
        .NUM_PADS (PADS)
    ) scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (sample_ch),
        .i_ev      (event_ch),
        .i_cfg     (reg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("piezo_trigger_to_midi_notes regression: fail");
            $finish;
        end
    end

    // Event sink: back-pressure decided fresh each cycle at the falling edge.
    always @(negedge i_clk) begin
        event_ch.ready = ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // One sample transaction. Entered at a falling edge, left at the falling
    // edge after acceptance with valid still high; the next call (or
    // stop_samples) decides what valid does next, so it never toggles twice.
    task automatic send_sample(input t_pad p, input t_sample s, input t_time t);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            sample_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid   = 1'b1;
        sample_ch.pad     = p;
        sample_ch.sample  = s;
        sample_ch.time_ms = t;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and let every outstanding event drain before touching registers.
    // Samples that make no event leave nothing to count, hence the extra wait.
    task automatic stop_samples();
        sample_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_idx idx, input t_cfg_data val);
        reg_ch.valid = 1'b1;
        reg_ch.index = idx;
        reg_ch.data  = val;
        @(posedge i_clk);
        while (!reg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        reg_ch.valid = 1'b0;
    endtask

    task automatic load_settings(input t_sample thr, input t_channel chan, input t_hold hold,
                                 input t_note n0, input t_note n1, input t_note n2,
                                 input t_note n3);
        reg_write(CFG_THRESHOLD, t_cfg_data'(thr));
        reg_write(CFG_CHANNEL, t_cfg_data'(chan));
        reg_write(CFG_HOLD, hold);
        reg_write(CFG_NOTE_PAD0, t_cfg_data'(n0));
        reg_write(CFG_NOTE_PAD1, t_cfg_data'(n1));
        reg_write(CFG_NOTE_PAD2, t_cfg_data'(n2));
        reg_write(CFG_NOTE_PAD3, t_cfg_data'(n3));
        cur_thr  = thr;
        cur_hold = hold;
        for (int i = 0; i < PADS; i++)
            armed[i] = 1'b0;
    endtask

    // One random sample. Many are strikes above the threshold, and many timestamps
    // sit near the pad's hold boundary, so pads cycle through on/off often.
    task automatic random_sample();
        t_pad        p;
        t_sample     s;
        t_time       t;
        t_time       since;
        int unsigned roll;
        int unsigned span;

        // three flow-control regimes across the random part
        if (rand_cnt < 200) begin
            send_idle_pct = 19;
            recv_idle_pct = 69;
        end else if (rand_cnt < 400) begin
            send_idle_pct = 69;
            recv_idle_pct = 19;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        rand_cnt++;

        p    = t_pad'($urandom_range(PADS - 1, 0));
        roll = $urandom_range(99, 0);
        if (roll < 45)
            s = (cur_thr < 1023) ? t_sample'($urandom_range(1023, cur_thr + 1))
                                 : t_sample'($urandom_range(1023, 0));
        else if (roll < 60)
            s = ($urandom_range(1, 0) || cur_thr == 1023) ? cur_thr : cur_thr + 10'd1;
        else if (roll < 70)
            s = $urandom_range(1, 0) ? 10'd0 : 10'd1023;
        else
            s = t_sample'($urandom_range(1023, 0));

        span = (cur_hold == '0) ? 1 : 32'(cur_hold);
        roll = $urandom_range(99, 0);
        if (roll < 45) begin
            clock_ms += $urandom_range(span / 6 + 1, 0);
            t = clock_ms;
        end else if (roll < 75) begin
            // one before, at, or one past the end of the hold window
            t = strike_ms[p] + span + $urandom_range(2, 0) - 1;
        end else if (roll < 85) begin
            t = $urandom();
        end else begin
            t = clock_ms;
        end

        since = t - strike_ms[p];
        if (!armed[p] && s > cur_thr) begin
            armed[p]     = 1'b1;
            strike_ms[p] = t;
        end else if (armed[p] && since >= span) begin
            armed[p] = 1'b0;
        end

        send_sample(p, s, t);
    endtask

    initial begin
        int n_items;

        sample_ch.valid   = 1'b0;
        sample_ch.pad     = '0;
        sample_ch.sample  = '0;
        sample_ch.time_ms = '0;
        reg_ch.valid      = 1'b0;
        reg_ch.index      = '0;
        reg_ch.data       = '0;
        clock_ms          = '0;
        for (int i = 0; i < PADS; i++) begin
            strike_ms[i] = '0;
            armed[i]     = 1'b0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // ---- directed, reset settings: threshold 100, hold 80, channel 0 ----
        send_sample(2'd0, 10'd1023, 32'd1000);         // full-scale hit, velocity 127
        send_sample(2'd0, 10'd1023, 32'd1079);         // still inside hold: ignored
        send_sample(2'd0, 10'd0, 32'd1080);            // hold reached: note-off
        send_sample(2'd1, 10'd101, 32'd0);             // just above threshold
        send_sample(2'd2, 10'd100, 32'd5);             // equal to threshold: nothing
        send_sample(2'd2, 10'd0, 32'd6);
        send_sample(2'd3, 10'd200, 32'hFFFF_FFF0);     // onset just before wrap
        send_sample(2'd3, 10'd999, 32'h0000_003F);     // 79 ms across the wrap
        send_sample(2'd3, 10'd1, 32'h0000_0040);       // 80 ms across the wrap: off
        send_sample(2'd1, 10'd500, 32'hFFFF_FFFF);     // huge elapsed time: off
        send_sample(2'd2, 10'd1022, 32'hAAAA_5555);
        send_sample(2'd2, 10'd0, 32'h5555_AAAA);
        send_sample(2'd0, 10'h2AA, 32'h0000_0000);
        send_sample(2'd0, 10'h155, 32'h0000_0050);
        stop_samples();

        // ---- directed, zero threshold and zero hold (acts as one) ----
        load_settings(10'd0, 4'd15, 16'd0, 7'd127, 7'd0, 7'd127, 7'd0);
        reg_write(CFG_UNUSED, 16'hFFFF);               // unmapped write, no effect
        send_sample(2'd0, 10'd1, 32'd10);              // velocity rounds to 0, raised to 1
        send_sample(2'd0, 10'd1023, 32'd10);           // same ms: hold not reached
        send_sample(2'd0, 10'd0, 32'd11);              // one ms later: off
        send_sample(2'd1, 10'd8, 32'd20);
        send_sample(2'd1, 10'd9, 32'd21);
        send_sample(2'd2, 10'd0, 32'd30);              // zero is not above zero
        send_sample(2'd3, 10'd1023, 32'd40);
        send_sample(2'd3, 10'd1023, 32'd41);
        stop_samples();

        // ---- random phases, each with its own register settings ----
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_settings(10'd0, 4'd15, 16'd0, 7'd0, 7'd127, 7'd0, 7'd127);
                1: load_settings(10'd1023, 4'd0, 16'd65535, 7'd127, 7'd0, 7'd127, 7'd0);
                2: load_settings(10'd512, 4'd7, 16'd65535, t_note'($urandom_range(127, 0)),
                                 t_note'($urandom_range(127, 0)),
                                 t_note'($urandom_range(127, 0)),
                                 t_note'($urandom_range(127, 0)));
                3: load_settings(10'd1, 4'd1, 16'd1, 7'd1, 7'd2, 7'd126, 7'd64);
                default: load_settings(t_sample'($urandom_range(1000, 0)),
                                       t_channel'($urandom_range(15, 0)),
                                       t_hold'($urandom_range(300, 1)),
                                       t_note'($urandom_range(127, 0)),
                                       t_note'($urandom_range(127, 0)),
                                       t_note'($urandom_range(127, 0)),
                                       t_note'($urandom_range(127, 0)));
            endcase
            // long hold: start just below the wrap so timestamps roll over
            clock_ms = (ph == 2) ? 32'hFFFF_0000 : $urandom();
            for (int i = 0; i < PADS; i++)
                strike_ms[i] = clock_ms;
            // full threshold leaves only pending note-offs, so keep it short
            n_items = (ph == 1) ? 25 : 80;
            for (int k = 0; k < n_items; k++)
                random_sample();
            stop_samples();
        end

        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("piezo_trigger_to_midi_notes regression: pass");
        else
            $display("piezo_trigger_to_midi_notes regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ptm_pkg.sv
sv/ptm_ifs.sv
sv/piezo_trigger_to_midi_notes.sv
dv/piezo_trigger_to_midi_notes_checker.sv
dv/piezo_trigger_to_midi_notes_test.sv
